>>> hw/rtl/csvft_pkg.sv
package csvft_pkg;

    localparam int ByteWidth  = 8;
    localparam int KindWidth  = 2;
    localparam int IndexWidth = 8;
    localparam int ModeWidth  = 2;
    localparam int CfgIdxWidth = 8;

    localparam int QueueDepth = 3;
    localparam int CountWidth = $clog2(QueueDepth + 1);

    localparam logic [ByteWidth-1:0] QuoteChar = 8'h22;
    localparam logic [ByteWidth-1:0] CrChar    = 8'h0D;
    localparam logic [ByteWidth-1:0] LfChar    = 8'h0A;
    localparam logic [ByteWidth-1:0] AposChar  = 8'h27;

    localparam logic [ByteWidth-1:0]  DelimReset  = 8'd44;
    localparam logic [IndexWidth-1:0] IndexMax    = 8'd255;

    localparam logic [ModeWidth-1:0] MODE_OUT       = 2'd0;
    localparam logic [ModeWidth-1:0] MODE_IN        = 2'd1;
    localparam logic [ModeWidth-1:0] MODE_IN_QUOTE  = 2'd2;
    localparam logic [ModeWidth-1:0] MODE_AFTER_EOL = 2'd3;

    localparam logic [KindWidth-1:0] KIND_DATA  = 2'd0;
    localparam logic [KindWidth-1:0] KIND_FIELD = 2'd1;
    localparam logic [KindWidth-1:0] KIND_ROW   = 2'd2;

    localparam logic [CfgIdxWidth-1:0] REG_DELIMITER = 8'd0;
    localparam logic [CfgIdxWidth-1:0] REG_ESCAPE    = 8'd1;

    typedef struct packed {
        logic [KindWidth-1:0]  kind;
        logic [ByteWidth-1:0]  data;
        logic [IndexWidth-1:0] index;
        logic                  last;
    } token_t;

endpackage

>>> hw/rtl/csv_field_tokenizer_top.sv
// A token is registered into the queue as its byte is taken; the head is output.
// Throughput: one byte per cycle while the output drains one token per cycle;
// a data apostrophe with escaping on yields two tokens and holds off input until
// a token drains, set by the single-token output port and the three-entry queue.
// Reset (rst_n low, asynchronous): queue empty, parser outside quotes, field
// index 0, delimiter comma, apostrophe escaping off.
module csv_field_tokenizer_top (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csvft_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [csvft_pkg::ByteWidth-1:0]   cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [csvft_pkg::ByteWidth-1:0]   in_byte,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [csvft_pkg::KindWidth-1:0]   token_kind,
    output logic [csvft_pkg::ByteWidth-1:0]   data_byte,
    output logic [csvft_pkg::IndexWidth-1:0]  field_index,
    output logic                              last_of_run
);
    import csvft_pkg::*;

    // Configuration registers
    logic [ByteWidth-1:0]  delim_reg;
    logic                  escape_reg;

    // Parser state
    logic [ModeWidth-1:0]  mode_reg;
    logic [ModeWidth-1:0]  mode_next;
    logic [IndexWidth-1:0] counter_reg;
    logic [IndexWidth-1:0] counter_next;

    // Token queue: entry 0 is the head shown on the output port
    token_t                queue_reg [QueueDepth];
    token_t                queue_next [QueueDepth];
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;

    logic                  in_fire;
    logic                  out_fire;
    logic [1:0]            n_tokens;
    logic                  outside;
    token_t                tok0;
    token_t                tok1;
    logic [CountWidth-1:0] base;

    assign cfg_ready = 1'b1;

    // Take a byte only while at least two queue slots are free, without looking
    // at out_ready, so in_ready is a register decode.
    assign in_ready  = (count_reg <= CountWidth'(QueueDepth - 2));
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;

    assign token_kind  = queue_reg[0].kind;
    assign data_byte   = queue_reg[0].data;
    assign field_index = queue_reg[0].index;
    assign last_of_run = queue_reg[0].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg  <= DelimReset;
            escape_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_DELIMITER)
            begin
                delim_reg <= cfg_data;
            end
            else if (cfg_index == REG_ESCAPE)
            begin
                escape_reg <= cfg_data[0];
            end
        end
    end

    // Parse one byte. Every token carries the field index as it was before this
    // byte, so field ends and row ends report the field they close.
    always_comb
    begin
        mode_next    = mode_reg;
        counter_next = counter_reg;
        n_tokens     = 2'd0;
        outside      = 1'b0;
        tok0         = '{kind: KIND_DATA, data: in_byte, index: counter_reg, last: 1'b1};
        tok1         = '{kind: KIND_DATA, data: in_byte, index: counter_reg, last: 1'b1};

        case (mode_reg)
            MODE_IN:
            begin
                if (in_byte == QuoteChar)
                begin
                    mode_next = MODE_IN_QUOTE;
                end
                else
                begin
                    n_tokens = 2'd1;
                end
            end
            MODE_IN_QUOTE:
            begin
                // Doubled quote gives a literal quote; anything else closes
                if (in_byte == QuoteChar)
                begin
                    mode_next = MODE_IN;
                    n_tokens  = 2'd1;
                end
                else
                begin
                    outside = 1'b1;
                end
            end
            MODE_AFTER_EOL:
            begin
                // Swallow one LF after a row end
                if (in_byte == LfChar)
                begin
                    mode_next = MODE_OUT;
                end
                else
                begin
                    outside = 1'b1;
                end
            end
            default:
            begin
                outside = 1'b1;
            end
        endcase

        if (outside)
        begin
            if (in_byte == QuoteChar)
            begin
                mode_next = MODE_IN;
            end
            else if (in_byte == delim_reg)
            begin
                mode_next  = MODE_OUT;
                n_tokens   = 2'd1;
                tok0.kind  = KIND_FIELD;
                tok0.data  = '0;
                if (counter_reg != IndexMax)
                begin
                    counter_next = counter_reg + 1'b1;
                end
            end
            else if (in_byte == CrChar || in_byte == LfChar)
            begin
                mode_next    = MODE_AFTER_EOL;
                n_tokens     = 2'd1;
                tok0.kind    = KIND_ROW;
                tok0.data    = '0;
                counter_next = '0;
            end
            else
            begin
                mode_next = MODE_OUT;
                n_tokens  = 2'd1;
            end
        end

        // Double a data apostrophe for SQL escaping
        if (n_tokens == 2'd1 && tok0.kind == KIND_DATA && escape_reg && in_byte == AposChar)
        begin
            n_tokens  = 2'd2;
            tok0.last = 1'b0;
        end
    end

    // Queue update: drop the head on an output beat, then append new tokens
    always_comb
    begin
        base       = count_reg - CountWidth'(out_fire);
        count_next = base;
        if (in_fire)
        begin
            count_next = base + CountWidth'(n_tokens);
        end

        for (int i = 0; i < QueueDepth; i++)
        begin
            if (out_fire && i < QueueDepth - 1)
            begin
                queue_next[i] = queue_reg[i + 1];
            end
            else
            begin
                queue_next[i] = queue_reg[i];
            end

            if (in_fire && n_tokens != 2'd0 && CountWidth'(i) == base)
            begin
                queue_next[i] = tok0;
            end
            else if (in_fire && n_tokens == 2'd2 && CountWidth'(i) == base + 1'b1)
            begin
                queue_next[i] = tok1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OUT;
            counter_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                mode_reg    <= mode_next;
                counter_reg <= counter_next;
            end
        end
    end

    // Payload holds without reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QueueDepth; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

endmodule

>>> tb/csv_field_tokenizer_top_tb.sv
`timescale 1ns / 1ps

module csv_field_tokenizer_top_tb;
    import csvft_pkg::*;

    // Out-of-range register indexes: writes to these must be dropped.
    localparam logic [CfgIdxWidth-1:0] REG_SPARE = 8'd2;
    localparam logic [CfgIdxWidth-1:0] REG_TOP   = 8'hFF;

    localparam logic [ByteWidth-1:0] TabChar = 8'h09;
    localparam logic [ByteWidth-1:0] LetterA = 8'h61;

    // Cycles to let pass after the last token before a register write or the end:
    // a byte that yields no token may still sit in the pipe.
    localparam int SettleCycles = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [ByteWidth-1:0]   cfg_data  = '0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [ByteWidth-1:0]   in_byte  = '0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [KindWidth-1:0]   token_kind;
    logic [ByteWidth-1:0]   data_byte;
    logic [IndexWidth-1:0]  field_index;
    logic                   last_of_run;

    csv_field_tokenizer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_kind  (token_kind),
        .data_byte   (data_byte),
        .field_index (field_index),
        .last_of_run (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tokenizer shadow: register copies, parse state and the tokens owed.
    // ------------------------------------------------------------------
    logic [ByteWidth-1:0]  field_delim = DelimReset;
    logic                  apos_double = 1'b0;
    logic [ModeWidth-1:0]  scan_mode   = MODE_OUT;
    logic [IndexWidth-1:0] field_pos   = '0;

    token_t byte_tokens [$];   // tokens of the byte being scanned
    token_t tokens_due  [$];   // tokens still owed by the block, oldest first
    logic [ByteWidth-1:0] byte_queue [$];

    int queued_bytes   = 0;
    int bytes_taken    = 0;
    int tokens_checked = 0;
    int rows_seen      = 0;
    int saturated_seen = 0;
    int reg_writes     = 0;
    int errors         = 0;
    bit calm           = 1'b0;   // no idling on either side while set

    function automatic token_t make_token(logic [KindWidth-1:0] kind,
                                          logic [ByteWidth-1:0] data);
        token_t t;
        t.kind  = kind;
        t.data  = data;
        t.index = field_pos;
        t.last  = 1'b0;
        return t;
    endfunction

    // A data byte; an apostrophe goes out twice when SQL escaping is on.
    function automatic void emit_data(logic [ByteWidth-1:0] b);
        byte_tokens.insert(byte_tokens.size(), make_token(KIND_DATA, b));
        if (apos_double && b == AposChar)
            byte_tokens.insert(byte_tokens.size(), make_token(KIND_DATA, b));
    endfunction

    // Byte seen outside quotes. Quote beats delimiter, delimiter beats line end.
    function automatic void scan_outside(logic [ByteWidth-1:0] b);
        if (b == QuoteChar)
        begin
            scan_mode = MODE_IN;
        end
        else
        begin
            scan_mode = MODE_OUT;
            if (b == field_delim)
            begin
                byte_tokens.insert(byte_tokens.size(), make_token(KIND_FIELD, '0));
                if (field_pos != IndexMax)
                    field_pos = field_pos + 1'b1;
            end
            else if (b == CrChar || b == LfChar)
            begin
                byte_tokens.insert(byte_tokens.size(), make_token(KIND_ROW, '0));
                field_pos = '0;
                scan_mode = MODE_AFTER_EOL;
            end
            else
            begin
                emit_data(b);
            end
        end
    endfunction

    // Advance the shadow by one accepted byte and queue the tokens it owes.
    function automatic void tokenize_byte(logic [ByteWidth-1:0] b);
        byte_tokens.delete();
        case (scan_mode)
            MODE_IN:
            begin
                if (b == QuoteChar)
                    scan_mode = MODE_IN_QUOTE;
                else
                    emit_data(b);
            end
            MODE_IN_QUOTE:
            begin
                // Doubled quote is a literal; anything else closes the section.
                if (b == QuoteChar)
                begin
                    scan_mode = MODE_IN;
                    emit_data(b);
                end
                else
                begin
                    scan_outside(b);
                end
            end
            MODE_AFTER_EOL:
            begin
                // Swallow one LF right after a line end.
                if (b == LfChar)
                    scan_mode = MODE_OUT;
                else
                    scan_outside(b);
            end
            default: scan_outside(b);
        endcase
        if (byte_tokens.size() != 0)
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i])
            tokens_due.insert(tokens_due.size(), byte_tokens[i]);
    endfunction

    function automatic void check_field(string what, logic [ByteWidth-1:0] want,
                                        logic [ByteWidth-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: feed bytes from byte_queue, idling at random unless calm.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                tokenize_byte(in_byte);
                bytes_taken++;
            end
            // Slot is free: present the next byte or idle this cycle.
            if (!in_valid || in_ready)
            begin
                if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 31))
                begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take token beats, stall at random, check against tokens_due.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : take_token
        token_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                tokens_checked++;
                if (token_kind == KIND_ROW)
                    rows_seen++;
                if (field_index == IndexMax)
                    saturated_seen++;
                if (tokens_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: token with nothing expected, expected none, %s %0d %0d %0d %0b",
                             $time, "got kind/data/index/last", token_kind, data_byte,
                             field_index, last_of_run);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", ByteWidth'(want.kind), ByteWidth'(token_kind));
                    check_field("data_byte", want.data, data_byte);
                    check_field("field_index", want.index, field_index);
                    check_field("last_of_run", ByteWidth'(want.last), ByteWidth'(last_of_run));
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [ByteWidth-1:0] b);
        byte_queue.insert(byte_queue.size(), b);
        queued_bytes++;
    endtask

    function automatic logic [ByteWidth-1:0] plain_byte();
        case ($urandom_range(9))
            0: return AposChar;
            1: return 8'($urandom_range(255));
            default: return LetterA + 8'($urandom_range(25));
        endcase
    endfunction

    // Quoted content leans on the bytes that mean something outside quotes.
    function automatic logic [ByteWidth-1:0] quoted_byte();
        case ($urandom_range(7))
            0: return field_delim;
            1: return CrChar;
            2: return LfChar;
            3: return AposChar;
            4: return 8'($urandom_range(255));
            default: return LetterA + 8'($urandom_range(25));
        endcase
    endfunction

    // Mostly well-formed rows with random content, some raw noise and some
    // quoted sections cut short by a lone quote.
    task automatic add_rows(input int budget);
        int target;
        int nf;
        int r;
        target = queued_bytes + budget;
        while (queued_bytes < target)
        begin
            if ($urandom_range(99) < 12)
            begin
                push_byte(8'($urandom_range(255)));
            end
            else
            begin
                nf = $urandom_range(1, 5);
                for (int f = 0; f < nf; f++)
                begin
                    if (f > 0)
                        push_byte(field_delim);
                    case ($urandom_range(3))
                        0: ;   // empty field
                        3:
                        begin
                            push_byte(QuoteChar);
                            repeat ($urandom_range(0, 6))
                            begin
                                r = $urandom_range(11);
                                if (r == 0)
                                begin
                                    push_byte(QuoteChar);
                                    push_byte(QuoteChar);
                                end
                                else if (r == 1)
                                begin
                                    push_byte(QuoteChar);
                                end
                                else
                                begin
                                    push_byte(quoted_byte());
                                end
                            end
                            push_byte(QuoteChar);
                        end
                        default: repeat ($urandom_range(1, 6)) push_byte(plain_byte());
                    endcase
                end
                case ($urandom_range(3))
                    0: push_byte(CrChar);
                    1: push_byte(LfChar);
                    default:
                    begin
                        push_byte(CrChar);
                        push_byte(LfChar);
                    end
                endcase
            end
        end
    endtask

    // Wait until every byte is taken and every owed token has arrived, then
    // hold SettleCycles more. Tokens still owed after the limit are failures.
    task automatic settle();
        int spins;
        spins = 0;
        while (bytes_taken != queued_bytes)
            @(posedge clk);
        while (tokens_due.size() != 0 && spins < 5000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (SettleCycles) @(posedge clk);
        if (tokens_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d tokens never arrived, oldest expected kind %0d data %0d",
                     $time, tokens_due.size(), tokens_due[0].kind, tokens_due[0].data);
            $display("%0t: oldest missing token expected index %0d, got nothing",
                     $time, tokens_due[0].index);
            tokens_due.delete();
        end
    endtask

    // One register write beat; the shadow copy follows on acceptance.
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [ByteWidth-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_DELIMITER)
            field_delim = val;
        else if (idx == REG_ESCAPE)
            apos_double = val[0];
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [ByteWidth-1:0] delim, input logic esc,
                             input bit quiet, input int budget);
        settle();
        write_reg(REG_DELIMITER, delim);
        write_reg(REG_ESCAPE, {7'd0, esc});
        calm = quiet;
        add_rows(budget);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [ByteWidth-1:0] seq [$];

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (comma, no escaping): plain and quoted fields, a
        // doubled quote, byte extremes, CRLF, empty rows, and a quote closed
        // by a line end.
        seq = '{LetterA, DelimReset, QuoteChar, 8'h78, QuoteChar, QuoteChar, QuoteChar,
                DelimReset, 8'h00, 8'hFF, AposChar, CrChar, LfChar, LfChar, CrChar,
                CrChar, QuoteChar, QuoteChar, LfChar};
        foreach (seq[i])
            push_byte(seq[i]);
        settle();

        // Out-of-range indexes must leave the settings alone.
        write_reg(REG_SPARE, 8'hA5);
        write_reg(REG_TOP, 8'h00);

        // Escaping on, delimiter set to the quote: quote keeps its quoting
        // meaning; apostrophes double both outside and inside quotes.
        write_reg(REG_ESCAPE, 8'd1);
        write_reg(REG_DELIMITER, QuoteChar);
        seq = '{AposChar, QuoteChar, AposChar, QuoteChar, QuoteChar, LfChar};
        foreach (seq[i])
            push_byte(seq[i]);
        settle();

        // Delimiter set to CR: CR ends only the field, LF still ends the row.
        write_reg(REG_DELIMITER, CrChar);
        seq = '{LetterA, CrChar, LfChar};
        foreach (seq[i])
            push_byte(seq[i]);

        // Random rows across delimiter and escape settings, extremes included.
        run_phase(DelimReset, 1'b1, 1'b0, 200);
        // One very wide row drives the field index into saturation.
        repeat (300) push_byte(DelimReset);
        push_byte(LfChar);
        run_phase(TabChar, 1'b0, 1'b1, 200);
        run_phase(8'h00, 1'b1, 1'b0, 200);
        run_phase(8'hFF, 1'b0, 1'b0, 200);
        run_phase(QuoteChar, 1'b1, 1'b0, 150);
        run_phase(LfChar, 1'b0, 1'b0, 150);
        run_phase(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 250);

        settle();
        calm = 1'b0;

        $display("Sent %0d bytes under %0d register writes; checked %0d tokens.",
                 bytes_taken, reg_writes, tokens_checked);
        $display("Saw %0d row ends and %0d tokens at the saturated field index.",
                 rows_seen, saturated_seen);
        if (errors == 0)
            $display("csv_field_tokenizer_top_tb: done, clean");
        else
            $display("csv_field_tokenizer_top_tb: done, errors");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #1000000;
        $display("Timeout: %0d of %0d bytes taken, %0d tokens owed", bytes_taken,
                 queued_bytes, tokens_due.size());
        $display("csv_field_tokenizer_top_tb: done, errors");
        $finish;
    end

endmodule
